// File: sv/rc_pulse_to_angle_and_range_core_defines.svh
// Assertion macros used by the checker of the pulse-to-angle core.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef RC_PULSE_TO_ANGLE_AND_RANGE_CORE_DEFINES_SVH
`define RC_PULSE_TO_ANGLE_AND_RANGE_CORE_DEFINES_SVH

// Same-cycle implication, inactive during reset
`define RCPAR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, inactive during reset
`define RCPAR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/rcpar_pkg.sv
// Types and constants for the pulse-to-angle-and-range core.
// No dependencies; used by the core and its checker.
package rcpar_pkg;

	// Full-scale results
	localparam int ANGLE_FULL = 4500;
	localparam int RANGE_FULL = 100;

	// Quotient bits resolved by the divider (covers ANGLE_FULL)
	localparam int QUO_BITS   = 13;
	localparam int VALUE_BITS = 14;
	localparam int DZ_BITS    = 10;

	// Configuration port
	localparam int CFG_ADDR_BITS = 3;

	// Register reset values
	localparam int RST_PULSE_MIN   = 1000;
	localparam int RST_PULSE_MAX   = 2000;
	localparam int RST_TRIM_CENTER = 1500;
	localparam int RST_DEAD_ZONE   = 0;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_PULSE_MIN   = 3'd0,
		REG_PULSE_MAX   = 3'd1,
		REG_TRIM_CENTER = 3'd2,
		REG_DEAD_ZONE   = 3'd3,
		REG_REVERSE     = 3'd4
	} reg_idx_t;

endpackage

// File: sv/rc_pulse_to_angle_and_range_core.sv
// Throughput: one item per cycle unless the output stalls; the pipeline is 5 setup stages,
// a 13-stage restoring divider (one quotient bit per stage) and an output register.
// A stall at the output holds every stage; in_ready falls only while a result waits.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the registers.
// Depends on rcpar_pkg.
module rc_pulse_to_angle_and_range_core #(
	parameter int PULSE_BITS = 12
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [rcpar_pkg::CFG_ADDR_BITS-1:0]         cfg_addr,
	input  logic [PULSE_BITS-1:0]                       cfg_wdata,
	input  logic                                        in_valid,
	output logic                                        in_ready,
	input  logic                                        func,
	input  logic [PULSE_BITS-1:0]                       pulse_width,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic signed [rcpar_pkg::VALUE_BITS-1:0]     value
);

	localparam int PW  = PULSE_BITS;
	localparam int DW  = PULSE_BITS + 3;          // signed differences
	localparam int MW  = PULSE_BITS + 2;          // magnitudes
	localparam int QB  = rcpar_pkg::QUO_BITS;
	localparam int NW  = MW + QB;                 // numerator / remainder
	localparam int OW  = rcpar_pkg::VALUE_BITS;
	localparam int DZW = rcpar_pkg::DZ_BITS;

	// Configuration registers
	logic [PW-1:0]  pulse_min_q;
	logic [PW-1:0]  pulse_max_q;
	logic [PW-1:0]  trim_center_q;
	logic [DZW-1:0] dead_zone_q;
	logic           reverse_q;

	// Values derived from the configuration
	logic signed [DW-1:0] min_x, max_x, trim_x, dz_x;
	logic signed [DW-1:0] band_hi_q, band_lo_q, up_den_q, dn_den_q;
	logic signed [DW-1:0] rng_lo_q, rng_span_q, mirror_q;

	// Pipeline
	logic                 adv;
	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic                 func_s1, func_s2, func_s3;
	logic [PW-1:0]        pulse_s1, r_s2;
	logic signed [DW-1:0] diff_s3, den_s3;
	logic                 act_s3, flip_s3;
	logic [NW-1:0]        num_s4;
	logic [MW-1:0]        den_s4;
	logic                 neg_s4;

	// Divider stages: entry k is stage 5+k
	logic [NW-1:0]        dv_rem_s5 [0:QB];
	logic [QB-1:0]        dv_quo_s5 [0:QB];
	logic [MW-1:0]        dv_den_s5 [0:QB];
	logic                 dv_neg_s5 [0:QB];
	logic                 dv_ovf_s5 [0:QB];
	logic                 dv_vld_s5 [0:QB];

	logic                 vld_s19;
	logic signed [OW-1:0] value_s19;

	// Combinational stage results
	logic [PW-1:0]        r_c;
	logic signed [DW-1:0] rx_c, rr_c, diff_c, den_c;
	logic                 act_c;
	logic signed [DW-1:0] dabs_c, nabs_c;
	logic [MW-1:0]        dmag_c, nmag_c;
	logic [QB-1:0]        scale_c;
	logic [NW-1:0]        prod_c;
	logic [QB-1:0]        mag_c;
	logic signed [OW-1:0] val_c;

	// Register writes; out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q   <= PW'(rcpar_pkg::RST_PULSE_MIN);
			pulse_max_q   <= PW'(rcpar_pkg::RST_PULSE_MAX);
			trim_center_q <= PW'(rcpar_pkg::RST_TRIM_CENTER);
			dead_zone_q   <= DZW'(rcpar_pkg::RST_DEAD_ZONE);
			reverse_q     <= 1'b0;
		end else if (cfg_we) begin
			case (rcpar_pkg::reg_idx_t'(cfg_addr))
				rcpar_pkg::REG_PULSE_MIN:   pulse_min_q   <= cfg_wdata;
				rcpar_pkg::REG_PULSE_MAX:   pulse_max_q   <= cfg_wdata;
				rcpar_pkg::REG_TRIM_CENTER: trim_center_q <= cfg_wdata;
				rcpar_pkg::REG_DEAD_ZONE:   dead_zone_q   <= cfg_wdata[DZW-1:0];
				rcpar_pkg::REG_REVERSE:     reverse_q     <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign min_x  = DW'(pulse_min_q);
	assign max_x  = DW'(pulse_max_q);
	assign trim_x = DW'(trim_center_q);
	assign dz_x   = DW'(dead_zone_q);

	// Precompute band edges and spans, registered from the configuration registers
	always_ff @(posedge clk) begin
		band_hi_q  <= trim_x + dz_x;
		band_lo_q  <= trim_x - dz_x;
		up_den_q   <= max_x - (trim_x + dz_x);
		dn_den_q   <= (trim_x - dz_x) - min_x;
		rng_lo_q   <= min_x + dz_x;
		rng_span_q <= max_x - (min_x + dz_x);
		mirror_q   <= max_x + min_x;
	end

	// Whole pipeline advances unless a result waits at the output
	assign adv      = !vld_s19 || out_ready;
	assign in_ready = adv;

	// Stage 2: clamp to the pulse limits
	always_comb begin
		if (pulse_s1 < pulse_min_q) begin
			r_c = pulse_min_q;
		end else if (pulse_s1 > pulse_max_q) begin
			r_c = pulse_max_q;
		end else begin
			r_c = pulse_s1;
		end
	end

	// Stage 3: pick the branch, its offset and its span
	always_comb begin
		rx_c   = DW'(r_s2);
		rr_c   = reverse_q ? (mirror_q - rx_c) : rx_c;
		diff_c = '0;
		den_c  = '0;
		act_c  = 1'b0;
		if (func_s2) begin
			if (rr_c > rng_lo_q && rng_span_q != '0) begin
				diff_c = rr_c - rng_lo_q;
				den_c  = rng_span_q;
				act_c  = 1'b1;
			end
		end else begin
			if (rx_c > band_hi_q && up_den_q != '0) begin
				diff_c = rx_c - band_hi_q;
				den_c  = up_den_q;
				act_c  = 1'b1;
			end else if (rx_c < band_lo_q && dn_den_q != '0) begin
				diff_c = rx_c - band_lo_q;
				den_c  = dn_den_q;
				act_c  = 1'b1;
			end
		end
	end

	// Stage 4: magnitudes, scaled numerator and result sign
	always_comb begin
		dabs_c  = diff_s3[DW-1] ? -diff_s3 : diff_s3;
		nabs_c  = den_s3[DW-1] ? -den_s3 : den_s3;
		dmag_c  = dabs_c[MW-1:0];
		nmag_c  = nabs_c[MW-1:0];
		scale_c = func_s3 ? QB'(rcpar_pkg::RANGE_FULL) : QB'(rcpar_pkg::ANGLE_FULL);
		prod_c  = NW'(dmag_c) * NW'(scale_c);
	end

	// Valid bits of the setup stages and the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s19 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= in_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s19 <= dv_vld_s5[QB];
		end
	end

	// Payload of the setup stages
	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= func;
			pulse_s1 <= pulse_width;
			func_s2  <= func_s1;
			r_s2     <= r_c;
			func_s3  <= func_s2;
			diff_s3  <= diff_c;
			den_s3   <= den_c;
			act_s3   <= act_c;
			flip_s3  <= reverse_q && !func_s2;
			// inactive items divide zero by one
			num_s4   <= act_s3 ? prod_c : '0;
			den_s4   <= act_s3 ? nmag_c : MW'(1);
			neg_s4   <= act_s3 && (diff_s3[DW-1] ^ den_s3[DW-1] ^ flip_s3);
		end
	end

	// Stage 5: load the divider and flag quotients beyond the resolved range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s5[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s5[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s5[0] <= num_s4;
			dv_quo_s5[0] <= '0;
			dv_den_s5[0] <= den_s4;
			dv_neg_s5[0] <= neg_s4;
			dv_ovf_s5[0] <= num_s4 >= {den_s4, {QB{1'b0}}};
		end
	end

	// Restoring divider: one quotient bit per stage, most significant first
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int B = QB - 1 - k;
		logic [NW-1:0] trial;
		logic          take;

		assign trial = NW'(dv_den_s5[k]) << B;
		assign take  = dv_rem_s5[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s5[k+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s5[k+1] <= dv_vld_s5[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s5[k+1] <= take ? (dv_rem_s5[k] - trial) : dv_rem_s5[k];
				dv_quo_s5[k+1] <= dv_quo_s5[k] | (QB'(take) << B);
				dv_den_s5[k+1] <= dv_den_s5[k];
				dv_neg_s5[k+1] <= dv_neg_s5[k];
				dv_ovf_s5[k+1] <= dv_ovf_s5[k];
			end
		end
	end

	// Output stage: saturate to full scale and apply the sign
	always_comb begin
		if (dv_ovf_s5[QB] || dv_quo_s5[QB] > QB'(rcpar_pkg::ANGLE_FULL)) begin
			mag_c = QB'(rcpar_pkg::ANGLE_FULL);
		end else begin
			mag_c = dv_quo_s5[QB];
		end
		val_c = dv_neg_s5[QB] ? -OW'(mag_c) : OW'(mag_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s19 <= val_c;
		end
	end

	assign out_valid = vld_s19;
	assign value     = value_s19;

endmodule

// File: sv/rcpar_checker.sv
// Port-level checks for the pulse-to-angle-and-range core, bound to its top level.
// Depends on rcpar_pkg and the assertion macros.
`include "rc_pulse_to_angle_and_range_core_defines.svh"

module rcpar_checker (
	input logic                                    clk,
	input logic                                    arst_n,
	input logic                                    in_ready,
	input logic                                    out_valid,
	input logic                                    out_ready,
	input logic signed [rcpar_pkg::VALUE_BITS-1:0] value
);

	// A waiting result holds until taken
	`RCPAR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value), "result changed while stalled")

	// Results never leave the full-scale range
	`RCPAR_ASSERT_SAME(a_value_range, out_valid, ($signed(value) <= rcpar_pkg::ANGLE_FULL) && ($signed(value) >= -rcpar_pkg::ANGLE_FULL), "result beyond full scale")

	// A stalled output backs up to the input
	`RCPAR_ASSERT_SAME(a_stall_back, out_valid && !out_ready, !in_ready, "item taken while output stalled")

	// With no result waiting, the input is open
	`RCPAR_ASSERT_SAME(a_open_ready, !out_valid, in_ready, "input closed with empty output")

endmodule

bind rc_pulse_to_angle_and_range_core rcpar_checker u_rcpar_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value)
);

// File: verif/rc_pulse_to_angle_and_range_core_tb.sv
// Self-checking testbench for rc_pulse_to_angle_and_range_core: drives pulse items under
// random sender bursts and receiver stalls, predicts every control value and checks it in order.
// Depends on rcpar_pkg and the core RTL only.
module rc_pulse_to_angle_and_range_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PULSE_BITS = 12;
	localparam logic [PULSE_BITS-1:0] PULSE_TOP = '1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PHASE_ITEMS = 250;
	localparam int RANDOM_PHASES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_SPACING = 700;
	localparam int REPORT_LIMIT = 10;

	// Mode codes carried on func
	localparam logic MODE_ANGLE = 1'b0;
	localparam logic MODE_RANGE = 1'b1;

	typedef struct packed {
		logic                  fn;
		logic [PULSE_BITS-1:0] pw;
	} pulse_item_t;

	logic                                        clk = 1'b0;
	logic                                        arst_n = 1'b0;
	logic                                        cfg_we = 1'b0;
	logic [rcpar_pkg::CFG_ADDR_BITS-1:0]         cfg_addr = '0;
	logic [PULSE_BITS-1:0]                       cfg_wdata = '0;
	logic                                        in_valid = 1'b0;
	logic                                        in_ready;
	logic                                        func = MODE_ANGLE;
	logic [PULSE_BITS-1:0]                       pulse_width = '0;
	logic                                        out_valid;
	logic                                        out_ready = 1'b0;
	logic signed [rcpar_pkg::VALUE_BITS-1:0]     value;

	// Mirror of the channel registers
	longint cfg_min = rcpar_pkg::RST_PULSE_MIN;
	longint cfg_max = rcpar_pkg::RST_PULSE_MAX;
	longint cfg_trim = rcpar_pkg::RST_TRIM_CENTER;
	longint cfg_dz = rcpar_pkg::RST_DEAD_ZONE;
	bit     cfg_rev = 1'b0;

	pulse_item_t                                 pending_items[$];
	logic signed [rcpar_pkg::VALUE_BITS-1:0]     expected_values[$];
	int unsigned                                 accepted_items = 0;
	int unsigned                                 errors_seen = 0;
	int                                          gap_left = 0;
	int                                          burst_left = 0;
	int                                          hold_left = 0;
	int unsigned                                 next_hold_at = 500;
	logic [15:0]                                 stall_pattern = '1;
	int                                          pattern_age = 0;

	rc_pulse_to_angle_and_range_core #(
		.PULSE_BITS(PULSE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.pulse_width(pulse_width),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value)
	);

	always #2 clk = ~clk;

	// Clamp, then map to centidegrees or to 0..100, then saturate
	function automatic logic signed [rcpar_pkg::VALUE_BITS-1:0] predict_control(input logic fn,
			input logic [PULSE_BITS-1:0] pw);
		longint r, hi, lo, span, v;
		r = pw;
		v = 0;
		if (r < cfg_min) begin
			r = cfg_min;
		end else if (r > cfg_max) begin
			r = cfg_max;
		end
		if (fn == MODE_RANGE) begin
			if (cfg_rev)
				r = cfg_max - (r - cfg_min);
			lo = cfg_min + cfg_dz;
			span = cfg_max - lo;
			if (r > lo && span != 0)
				v = (rcpar_pkg::RANGE_FULL * (r - lo)) / span;
		end else begin
			hi = cfg_trim + cfg_dz;
			lo = cfg_trim - cfg_dz;
			if (r > hi && cfg_max != hi) begin
				v = (rcpar_pkg::ANGLE_FULL * (r - hi)) / (cfg_max - hi);
			end else if (r < lo && lo != cfg_min) begin
				v = (rcpar_pkg::ANGLE_FULL * (r - lo)) / (lo - cfg_min);
			end
			if (cfg_rev)
				v = -v;
		end
		if (v > rcpar_pkg::ANGLE_FULL)
			v = rcpar_pkg::ANGLE_FULL;
		if (v < -rcpar_pkg::ANGLE_FULL)
			v = -rcpar_pkg::ANGLE_FULL;
		return v[rcpar_pkg::VALUE_BITS-1:0];
	endfunction

	// Pick a pulse: anywhere, inside the window, or close to an edge of the current setting
	function automatic logic [PULSE_BITS-1:0] pick_pulse();
		longint win_lo, win_hi, anchor;
		win_lo = (cfg_min < cfg_max) ? cfg_min : cfg_max;
		win_hi = (cfg_min < cfg_max) ? cfg_max : cfg_min;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				anchor = $urandom_range(0, PULSE_TOP);
			end
			3, 4, 5, 6: begin
				anchor = $urandom_range(win_lo, win_hi);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: anchor = cfg_min;
					1: anchor = cfg_max;
					2: anchor = cfg_trim + cfg_dz;
					3: anchor = cfg_trim - cfg_dz;
					default: anchor = cfg_min + cfg_dz;
				endcase
				anchor = anchor + longint'($urandom_range(0, 4)) - 2;
			end
		endcase
		if (anchor < 0)
			anchor = 0;
		if (anchor > longint'(PULSE_TOP))
			anchor = longint'(PULSE_TOP);
		return anchor[PULSE_BITS-1:0];
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		errors_seen++;
		if (errors_seen <= REPORT_LIMIT)
			$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// Write one register and keep the mirror in step; spare indexes change nothing
	task automatic write_reg(input logic [rcpar_pkg::CFG_ADDR_BITS-1:0] idx,
			input logic [PULSE_BITS-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		case (idx)
			rcpar_pkg::REG_PULSE_MIN:   cfg_min = data;
			rcpar_pkg::REG_PULSE_MAX:   cfg_max = data;
			rcpar_pkg::REG_TRIM_CENTER: cfg_trim = data;
			rcpar_pkg::REG_DEAD_ZONE:   cfg_dz = data[rcpar_pkg::DZ_BITS-1:0];
			rcpar_pkg::REG_REVERSE:     cfg_rev = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_channel(input logic [PULSE_BITS-1:0] lo_us,
			input logic [PULSE_BITS-1:0] hi_us,
			input logic [PULSE_BITS-1:0] trim_us, input logic [PULSE_BITS-1:0] dz_us,
			input logic [PULSE_BITS-1:0] rev);
		write_reg(rcpar_pkg::REG_PULSE_MIN, lo_us);
		write_reg(rcpar_pkg::REG_PULSE_MAX, hi_us);
		write_reg(rcpar_pkg::REG_TRIM_CENTER, trim_us);
		write_reg(rcpar_pkg::REG_DEAD_ZONE, dz_us);
		write_reg(rcpar_pkg::REG_REVERSE, rev);
	endtask

	// Choose a random channel setting of the given flavour
	task automatic pick_channel(input int flavour);
		longint lo_us, hi_us, trim_us, dz_us;
		case (flavour)
			0: begin
				lo_us = $urandom_range(800, 1200);
				hi_us = $urandom_range(1800, 2200);
				trim_us = $urandom_range(lo_us, hi_us);
				dz_us = $urandom_range(0, 300);
			end
			1: begin
				lo_us = $urandom_range(0, PULSE_TOP);
				hi_us = $urandom_range(0, PULSE_TOP);
				trim_us = $urandom_range(0, PULSE_TOP);
				dz_us = $urandom_range(0, PULSE_TOP);
				if ($urandom_range(0, 2) == 0) begin
					lo_us = 0;
					hi_us = longint'(PULSE_TOP);
					trim_us = $urandom_range(0, 1) ? longint'(PULSE_TOP) : 0;
				end
			end
			2: begin
				lo_us = $urandom_range(0, 3000);
				dz_us = $urandom_range(0, 500);
				case ($urandom_range(0, 2))
					0: begin
						hi_us = lo_us;
						trim_us = lo_us;
					end
					1: begin
						trim_us = lo_us + dz_us;
						hi_us = trim_us + dz_us;
					end
					default: begin
						hi_us = lo_us + dz_us;
						trim_us = $urandom_range(0, PULSE_TOP);
					end
				endcase
			end
			default: begin
				lo_us = $urandom_range(2048, PULSE_TOP);
				hi_us = $urandom_range(0, 2047);
				trim_us = $urandom_range(0, PULSE_TOP);
				dz_us = $urandom_range(0, 1023);
			end
		endcase
		set_channel(lo_us[PULSE_BITS-1:0], hi_us[PULSE_BITS-1:0], trim_us[PULSE_BITS-1:0],
			dz_us[PULSE_BITS-1:0], PULSE_BITS'($urandom_range(0, PULSE_TOP)));
	endtask

	task automatic queue_pulse(input logic fn, input logic [PULSE_BITS-1:0] pw);
		pulse_item_t item;
		item.fn = fn;
		item.pw = pw;
		pending_items.push_back(item);
	endtask

	// Return once every queued item has been sent and answered
	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_values.size() != 0)
			@(negedge clk);
	endtask

	// Sender: offer queued items in bursts, predict each one as it is accepted
	always @(posedge clk) begin : sender
		pulse_item_t item;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
			burst_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_values.push_back(predict_control(func, pulse_width));
				accepted_items <= accepted_items + 1;
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item = pending_items.pop_front();
					in_valid <= 1'b1;
					func <= item.fn;
					pulse_width <= item.pw;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off every few hundred items, so the pipeline fills and backs up
	always @(posedge clk) begin : receiver_hold
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (accepted_items >= next_hold_at) begin
			hold_left <= HOLD_CYCLES;
			next_hold_at <= next_hold_at + HOLD_SPACING;
		end
	end

	// Receiver: stall on a rotating pattern, check each result against the oldest prediction
	always @(posedge clk) begin : receiver
		logic signed [rcpar_pkg::VALUE_BITS-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_pattern <= '1;
			pattern_age <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					note_mismatch("result with no item outstanding", 0, value);
				end else begin
					want = expected_values.pop_front();
					if (value !== want)
						note_mismatch("value", want, value);
				end
			end
			if (pattern_age == 0) begin
				stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h1);
				pattern_age <= 63;
			end else begin
				stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
				pattern_age <= pattern_age - 1;
			end
			out_ready <= stall_pattern[0] && hold_left == 0;
		end
	end

	// Watchdog
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus: directed settings first, then random settings with random pulses
	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset setting: limits, centre and both modes
		queue_pulse(MODE_ANGLE, '0);
		queue_pulse(MODE_ANGLE, PULSE_TOP);
		queue_pulse(MODE_ANGLE, 1500);
		queue_pulse(MODE_ANGLE, 1250);
		queue_pulse(MODE_ANGLE, 1750);
		queue_pulse(MODE_RANGE, '0);
		queue_pulse(MODE_RANGE, PULSE_TOP);
		queue_pulse(MODE_RANGE, 1500);
		wait_idle();

		// Band edges sitting on both limits (zero spans in angle mode), and range mode
		set_channel(1000, 2000, 1500, 500, 0);
		@(negedge clk);
		queue_pulse(MODE_ANGLE, 1800);
		queue_pulse(MODE_ANGLE, 1200);
		queue_pulse(MODE_RANGE, 2000);
		queue_pulse(MODE_RANGE, 1500);
		wait_idle();

		// Inverted limits with reverse; spare indexes must leave the setting alone
		set_channel(3000, 1000, 2000, 100, 1);
		for (int a = int'(rcpar_pkg::REG_REVERSE) + 1; a < (1 << rcpar_pkg::CFG_ADDR_BITS); a++)
			write_reg(a[rcpar_pkg::CFG_ADDR_BITS-1:0], PULSE_BITS'($urandom()));
		@(negedge clk);
		queue_pulse(MODE_ANGLE, 500);
		queue_pulse(MODE_ANGLE, 3500);
		queue_pulse(MODE_ANGLE, 2000);
		queue_pulse(MODE_RANGE, 500);
		queue_pulse(MODE_RANGE, 3500);
		wait_idle();

		// Full-scale limits, widest dead band (upper data bits must be dropped)
		set_channel(0, PULSE_TOP, 0, PULSE_TOP, 1);
		@(negedge clk);
		queue_pulse(MODE_ANGLE, '0);
		queue_pulse(MODE_ANGLE, PULSE_TOP);
		queue_pulse(MODE_ANGLE, 2048);
		queue_pulse(MODE_RANGE, '0);
		queue_pulse(MODE_RANGE, PULSE_TOP);
		queue_pulse(MODE_RANGE, 1023);
		queue_pulse(MODE_RANGE, 1024);
		wait_idle();

		// Random settings, each followed by a run of random pulses
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pick_channel(p % 4);
			@(negedge clk);
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_pulse(1'($urandom_range(0, 1)), pick_pulse());
			wait_idle();
		end

		// Let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors_seen == 0 && expected_values.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: rc_pulse_to_angle_and_range_core.f
+incdir+sv
sv/rcpar_pkg.sv
sv/rc_pulse_to_angle_and_range_core.sv
sv/rcpar_checker.sv
verif/rc_pulse_to_angle_and_range_core_tb.sv
